[hdl/thd_pkg.sv]
// thd_pkg: shared types, widths, reset values and register codes of the
// two-material heat diffusion step block. No dependencies.
`default_nettype none

package thd_pkg;

  localparam int TEMP_W      = 24;
  localparam int COEF_W      = 16;
  localparam int DIFF_W      = TEMP_W + 2;
  localparam int PROD_W      = COEF_W + 1 + DIFF_W;
  localparam int FRAC_SHIFT  = 16;
  localparam int SH_W        = PROD_W - FRAC_SHIFT;
  localparam int ACC_W       = SH_W + 1;
  localparam int STEP_W      = 16;
  localparam int SHOWN_CELLS = 7;
  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 5;

  localparam int NUM_CELLS_DEF      = 7;
  localparam int INTERFACE_CELL_DEF = 4;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic        [COEF_W-1:0] coef_t;
  typedef logic        [STEP_W-1:0] step_t;

  localparam temp_t TEMP_MAX = 24'sh7FFFFF;
  localparam temp_t TEMP_MIN = -24'sh800000;
  localparam step_t STEP_MAX = '1;

  localparam coef_t C1_RST    = 16'd17554;
  localparam coef_t C2_RST    = 16'd36409;
  localparam temp_t LEFT_RST  = 24'sd1802240;
  localparam temp_t RIGHT_RST = 24'sd327680;
  localparam temp_t INIT_RST  = 24'sd327680;
  localparam temp_t ALARM_RST = 24'sd344064;

  // register index codes
  localparam logic [2:0] REG_C1    = 3'd0;
  localparam logic [2:0] REG_C2    = 3'd1;
  localparam logic [2:0] REG_LEFT  = 3'd2;
  localparam logic [2:0] REG_RIGHT = 3'd3;
  localparam logic [2:0] REG_INIT  = 3'd4;
  localparam logic [2:0] REG_ALARM = 3'd5;

  // one multiply-accumulate operation for the datapath
  typedef struct packed {
    logic                     valid;
    logic                     first;
    logic                     last;
    coef_t                    coef;
    logic signed [DIFF_W-1:0] diff;
    temp_t                    base;
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

endpackage

`default_nettype wire

[hdl/two_material_heat_diffusion_step.sv]
// two_material_heat_diffusion_step: top level with config registers, cell
// sequencer, output register. Uses thd_pkg, thd_ram, thd_alu.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------
//   in      | input     | in_valid_i / in_ready_o  | restart_i
//   out     | output    | out_valid_o / out_ready_i| temp_cell0..6, step_count,
//           |           |                          | crossed, crossing_step
//   cfg     | input     | psel/penable/pwrite      | paddr, pwdata, prdata
//
// in a step beat the cell memory is read one cell per cycle through its
// single read port, pausing after the interface cell for its second op,
// then the multiply and accumulate pipeline drains. a restart beat goes
// straight to the done state. after reset every cell reads as the reset
// initial temperature through per-cell valid bits, no clearing pass.
// a new beat is taken in the cycle the previous result moves to the output
// register; a stalled output holds the next result in the engine.
`default_nettype none

module two_material_heat_diffusion_step #(
  parameter int          NUM_CELLS      = thd_pkg::NUM_CELLS_DEF,
  parameter int unsigned INTERFACE_CELL = thd_pkg::INTERFACE_CELL_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        restart_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output thd_pkg::temp_t                   temp_cell0_o,
  output thd_pkg::temp_t                   temp_cell1_o,
  output thd_pkg::temp_t                   temp_cell2_o,
  output thd_pkg::temp_t                   temp_cell3_o,
  output thd_pkg::temp_t                   temp_cell4_o,
  output thd_pkg::temp_t                   temp_cell5_o,
  output thd_pkg::temp_t                   temp_cell6_o,
  output thd_pkg::step_t                   step_count_o,
  output logic                             crossed_o,
  output thd_pkg::step_t                   crossing_step_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [thd_pkg::PADDR_W-1:0] paddr,
  input  wire logic [thd_pkg::APB_DW-1:0]  pwdata,
  output logic      [thd_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  import thd_pkg::*;

  localparam int ADDR_W = $clog2(NUM_CELLS);
  localparam int CNT_W  = $clog2(NUM_CELLS + 1);
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(NUM_CELLS - 1);
  localparam logic [CNT_W-1:0]  RD_END   = CNT_W'(NUM_CELLS);

  // ---------------- configuration registers ----------------
  coef_t      c1_q, c2_q;
  temp_t      left_q, right_q, init_q, alarm_lvl_q;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q        <= C1_RST;
      c2_q        <= C2_RST;
      left_q      <= LEFT_RST;
      right_q     <= RIGHT_RST;
      init_q      <= INIT_RST;
      alarm_lvl_q <= ALARM_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_C1:    c1_q        <= pwdata[COEF_W-1:0];
        REG_C2:    c2_q        <= pwdata[COEF_W-1:0];
        REG_LEFT:  left_q      <= pwdata[TEMP_W-1:0];
        REG_RIGHT: right_q     <= pwdata[TEMP_W-1:0];
        REG_INIT:  init_q      <= pwdata[TEMP_W-1:0];
        REG_ALARM: alarm_lvl_q <= pwdata[TEMP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_C1:    prdata = {{(APB_DW-COEF_W){1'b0}}, c1_q};
      REG_C2:    prdata = {{(APB_DW-COEF_W){1'b0}}, c2_q};
      REG_LEFT:  prdata = {{(APB_DW-TEMP_W){1'b0}}, left_q};
      REG_RIGHT: prdata = {{(APB_DW-TEMP_W){1'b0}}, right_q};
      REG_INIT:  prdata = {{(APB_DW-TEMP_W){1'b0}}, init_q};
      REG_ALARM: prdata = {{(APB_DW-TEMP_W){1'b0}}, alarm_lvl_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------- control ----------------
  state_e state_q, state_d;
  logic   in_ready, commit, accept, start_step, do_restart;
  logic   ovld_q, last_wr;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = restart_i ? S_DONE : S_RUN;
      end
      S_RUN: begin
        if (last_wr) state_d = S_DONE;
      end
      S_DONE: begin
        if (accept) state_d = restart_i ? S_DONE : S_RUN;
        else if (commit) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    commit     = (state_q == S_DONE) && (!ovld_q || out_ready_i);
    in_ready   = (state_q == S_IDLE) || commit;
    accept     = in_valid_i && in_ready;
    start_step = accept && !restart_i;
    do_restart = accept && restart_i;
  end

  assign in_ready_o = in_ready;

  // ---------------- cell fetch and window ----------------
  logic [CNT_W-1:0]     rd_cnt_q;
  logic [ADDR_W-1:0]    rd_addr, ridx_q, wr_cnt_q, ev_idx;
  logic                 rd_issue, rvld_q, vsel_q, hold;
  logic [NUM_CELLS-1:0] vld_q;
  temp_t                fill_q, rdata, rval, lft_q, mid_q, ev_r;
  logic                 arr_ev, tail_ev, ev_valid, tail_q, pb_q, is_lo, is_if;
  logic signed [DIFF_W-1:0] el, et, er, dl, dr, d2, pb_diff_q;
  temp_t                pb_t_q;
  op_t                  op;
  logic                 wr_valid;
  temp_t                wr_data;
  step_t                steps_q, astep_q;
  logic                 alarm_q;

  assign rd_addr  = rd_cnt_q[ADDR_W-1:0];
  assign rd_issue = (state_q == S_RUN) && (rd_cnt_q < RD_END) && !hold;
  // never-written cells read as the fill value
  assign rval     = vsel_q ? rdata : fill_q;

  always_comb begin
    arr_ev   = rvld_q && (ridx_q != '0);
    tail_ev  = tail_q && !pb_q;
    ev_valid = arr_ev || tail_ev;
    ev_idx   = tail_ev ? LAST_IDX : ridx_q - ADDR_W'(1);
    ev_r     = tail_ev ? right_q : rval;
    is_lo    = 32'(ev_idx) < INTERFACE_CELL;
    is_if    = 32'(ev_idx) == INTERFACE_CELL;
    // second half of the interface cell needs the next slot free
    hold     = arr_ev && is_if;
    el       = DIFF_W'(lft_q);
    et       = DIFF_W'(mid_q);
    er       = DIFF_W'(ev_r);
    dl       = el - et;
    dr       = er - et;
    d2       = el + er - (et <<< 1);
  end

  always_comb begin
    op = '0;
    if (pb_q) begin
      op.valid = 1'b1;
      op.first = 1'b0;
      op.last  = 1'b1;
      op.coef  = c2_q;
      op.diff  = pb_diff_q;
      op.base  = pb_t_q;
    end else if (ev_valid) begin
      op.valid = 1'b1;
      op.first = 1'b1;
      op.base  = mid_q;
      if (is_lo) begin
        op.last = 1'b1;
        op.coef = c1_q;
        op.diff = d2;
      end else if (is_if) begin
        op.last = 1'b0;
        op.coef = c1_q;
        op.diff = dl;
      end else begin
        op.last = 1'b1;
        op.coef = c2_q;
        op.diff = d2;
      end
    end
  end

  assign last_wr = wr_valid && (wr_cnt_q == LAST_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_cnt_q <= '0;
      wr_cnt_q <= '0;
      rvld_q   <= 1'b0;
      tail_q   <= 1'b0;
      pb_q     <= 1'b0;
      vld_q    <= '0;
      fill_q   <= INIT_RST;
      steps_q  <= '0;
      alarm_q  <= 1'b0;
      astep_q  <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      rvld_q  <= rd_issue;
      pb_q    <= ev_valid && is_if;

      if (start_step) begin
        rd_cnt_q <= '0;
        wr_cnt_q <= '0;
        steps_q  <= (steps_q == STEP_MAX) ? steps_q : steps_q + step_t'(1);
      end else begin
        if (rd_issue) rd_cnt_q <= rd_cnt_q + CNT_W'(1);
        if (wr_valid) wr_cnt_q <= wr_cnt_q + ADDR_W'(1);
      end

      if (arr_ev && (ridx_q == LAST_IDX)) tail_q <= 1'b1;
      else if (tail_ev) tail_q <= 1'b0;

      if (do_restart) begin
        vld_q   <= '0;
        fill_q  <= init_q;
        steps_q <= '0;
        alarm_q <= 1'b0;
        astep_q <= '0;
      end else begin
        if (wr_valid) vld_q[wr_cnt_q] <= 1'b1;
        // old rightmost cell, checked before its update
        if (rvld_q && (ridx_q == LAST_IDX) && !alarm_q && (rval > alarm_lvl_q)) begin
          alarm_q <= 1'b1;
          astep_q <= steps_q;
        end
      end

      if (commit) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= rd_addr;
    vsel_q <= vld_q[rd_addr];
    if (rvld_q) begin
      lft_q <= (ridx_q == '0) ? left_q : mid_q;
      mid_q <= rval;
    end
    if (ev_valid && is_if) begin
      pb_diff_q <= dr;
      pb_t_q    <= mid_q;
    end
  end

  thd_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (NUM_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_valid),
    .waddr_i (wr_cnt_q),
    .wdata_i (wr_data),
    .re_i    (rd_issue),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  thd_alu u_alu (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (op),
    .wr_valid_o (wr_valid),
    .wr_data_o  (wr_data)
  );

  // ---------------- shown cells and output register ----------------
  temp_t shown [SHOWN_CELLS];
  temp_t ocell_q [SHOWN_CELLS];
  step_t ostep_q, ocstep_q;
  logic  ocross_q;

  for (genvar k = 0; k < SHOWN_CELLS; k++) begin : g_show
    if (k < NUM_CELLS) begin : g_cell
      temp_t cell_q;
      always_ff @(posedge clk_i) begin
        if (do_restart) begin
          cell_q <= init_q;
        end else if (wr_valid && (wr_cnt_q == ADDR_W'(k))) begin
          cell_q <= wr_data;
        end
      end
      assign shown[k] = cell_q;
    end else begin : g_none
      assign shown[k] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      ocell_q  <= shown;
      ostep_q  <= steps_q;
      ocross_q <= alarm_q;
      ocstep_q <= astep_q;
    end
  end

  assign out_valid_o     = ovld_q;
  assign temp_cell0_o    = ocell_q[0];
  assign temp_cell1_o    = ocell_q[1];
  assign temp_cell2_o    = ocell_q[2];
  assign temp_cell3_o    = ocell_q[3];
  assign temp_cell4_o    = ocell_q[4];
  assign temp_cell5_o    = ocell_q[5];
  assign temp_cell6_o    = ocell_q[6];
  assign step_count_o    = ostep_q;
  assign crossed_o       = ocross_q;
  assign crossing_step_o = ocstep_q;

endmodule

`default_nettype wire

[hdl/thd_ram.sv]
// thd_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
`default_nettype none

module thd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/thd_alu.sv]
// thd_alu: pipelined multiply-accumulate for one cell update: coefficient
// times difference, arithmetic shift, accumulate, saturate. Uses thd_pkg.
`default_nettype none

module thd_alu (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire thd_pkg::op_t op_i,
  output logic              wr_valid_o,
  output thd_pkg::temp_t    wr_data_o
);

  import thd_pkg::*;

  op_t                      op_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic                     v2_q, f2_q, l2_q;
  temp_t                    base2_q;
  logic signed [SH_W-1:0]   shifted;
  logic signed [ACC_W-1:0]  sum, acc_q;

  // stage 1: multiply
  assign prod_d = $signed({1'b0, op_q.coef}) * $signed(op_q.diff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
      v2_q <= 1'b0;
    end else begin
      op_q <= op_i;
      v2_q <= op_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    f2_q       <= op_q.first;
    l2_q       <= op_q.last;
    base2_q    <= op_q.base;
    if (v2_q) begin
      acc_q <= sum;
    end
  end

  // stage 2: floor shift and accumulate; the interface cell takes two ops
  always_comb begin
    shifted = $signed(prod_q[PROD_W-1:FRAC_SHIFT]);
    sum     = (f2_q ? ACC_W'(base2_q) : acc_q) + ACC_W'(shifted);
  end

  always_comb begin
    if (sum > ACC_W'(TEMP_MAX)) begin
      wr_data_o = TEMP_MAX;
    end else if (sum < ACC_W'(TEMP_MIN)) begin
      wr_data_o = TEMP_MIN;
    end else begin
      wr_data_o = sum[TEMP_W-1:0];
    end
  end

  assign wr_valid_o = v2_q && l2_q;

endmodule

`default_nettype wire

[hdl/thd_chk.sv]
// thd_chk: port-level checker for two_material_heat_diffusion_step, bound
// to the top level. Uses thd_pkg types.
`default_nettype none

module thd_chk (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire thd_pkg::temp_t temp_cell6_o,
  input wire thd_pkg::step_t step_count_o,
  input wire logic           crossed_o,
  input wire thd_pkg::step_t crossing_step_o
);

  import thd_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // a stalled result beat keeps its step count and cell 6 temperature
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(step_count_o) && $stable(temp_cell6_o))
    else $error("output payload changed while stalled");

  // no crossing recorded means no crossing step
  a_no_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !crossed_o |-> crossing_step_o == '0)
    else $error("crossing step set without crossing");

  // a crossing lies within the steps taken so far
  a_cross_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && crossed_o |-> (crossing_step_o != '0) && (crossing_step_o <= step_count_o))
    else $error("crossing step out of range");

endmodule

bind two_material_heat_diffusion_step thd_chk u_thd_chk (.*);

`default_nettype wire
